### hw/rtl/tbe_pkg.sv
// ----------------------------------------------------------------------------
// tbe_pkg: shared types and constants of the tile expander
// Item kinds, tile geometry, address width, and the work record that moves
// from the front end to the output sequencer.
// ----------------------------------------------------------------------------
package tbe_pkg;

    // Geometry and sizes.
    localparam int ADDR_W        = 17;
    localparam int ROW_STRIDE    = 128;
    localparam int TILE_ROWS     = 16;
    localparam int PAL_ENTRIES   = 16;
    localparam int PAL_IDX_W     = $clog2(PAL_ENTRIES);
    localparam int ROW_W         = $clog2(TILE_ROWS);
    localparam int BYTES_PER_ROW = 4;
    localparam int COUNT_W       = ROW_W + 2;
    localparam int TILE_COL_STEP = 8;

    // Work queue depth.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Item kinds.
    typedef enum logic [1:0] {
        KIND_PALETTE = 2'd0,
        KIND_HEADER  = 2'd1,
        KIND_PATTERN = 2'd2,
        KIND_UNUSED  = 2'd3
    } t_kind;

    // One pattern byte, already resolved to colors and its first address.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [7:0]        left;
        logic [7:0]        right;
        logic              last;
    } t_work;

    // Color n of a palette word sits at bits 4n+3..4n.
    function automatic logic [3:0] color_of(input logic [15:0] word, input logic [1:0] pix);
        logic [3:0] c;
        unique case (pix)
            2'd0: c = word[3:0];
            2'd1: c = word[7:4];
            2'd2: c = word[11:8];
            2'd3: c = word[15:12];
            default: c = word[3:0];
        endcase
        return c;
    endfunction

endpackage

### hw/rtl/tbe_front.sv
// ----------------------------------------------------------------------------
// tbe_front: input classification and tile state
// Accepts input transactions, keeps the palette store and the current tile,
// and turns each pattern byte into a work record for the output sequencer.
// ----------------------------------------------------------------------------
module tbe_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_kind,
    input  logic [3:0]                 i_palette_index,
    input  logic [15:0]                i_palette_word,
    input  logic [7:0]                 i_tile_id,
    input  logic [7:0]                 i_color_byte,
    input  logic [7:0]                 i_pattern_byte,
    input  logic                       i_cfg_we,
    input  logic [tbe_pkg::ADDR_W-1:0] i_cfg_wdata,
    input  logic                       i_q_full,
    output logic                       o_push,
    output tbe_pkg::t_work             o_work
);

    logic [15:0]                  r_pal_mem [tbe_pkg::PAL_ENTRIES];
    logic [15:0]                  r_top_palette;
    logic [15:0]                  r_bottom_palette;
    logic [tbe_pkg::ADDR_W-1:0]   r_tile_base;
    logic [tbe_pkg::ADDR_W-1:0]   r_vram_base;
    logic [tbe_pkg::COUNT_W-1:0]  r_count;

    logic                         accept;
    tbe_pkg::t_kind               kind;
    logic [tbe_pkg::ADDR_W-1:0]   n_tile_base;
    logic [tbe_pkg::ROW_W-1:0]    row;
    logic [1:0]                   col;
    logic [15:0]                  word;
    logic [3:0]                   top_idx;
    logic [3:0]                   bot_idx;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign kind       = tbe_pkg::t_kind'(i_kind);
    assign top_idx    = i_color_byte[7:4];
    assign bot_idx    = i_color_byte[3:0];

    // Palette store: one write port, two read ports registered into the tile palettes.
    always_ff @(posedge i_clk) begin
        if (accept && kind == tbe_pkg::KIND_PALETTE
                && 32'(i_palette_index) < tbe_pkg::PAL_ENTRIES) begin
            r_pal_mem[i_palette_index[tbe_pkg::PAL_IDX_W-1:0]] <= i_palette_word;
        end
    end

    // Tile base from the tile row and column of the header.
    assign n_tile_base = r_vram_base
        + tbe_pkg::ADDR_W'(i_tile_id[7:4]) * tbe_pkg::ADDR_W'(tbe_pkg::TILE_ROWS * tbe_pkg::ROW_STRIDE)
        + tbe_pkg::ADDR_W'(i_tile_id[3:0]) * tbe_pkg::ADDR_W'(tbe_pkg::TILE_COL_STEP);

    // Configuration register and current tile state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vram_base      <= '0;
            r_top_palette    <= '0;
            r_bottom_palette <= '0;
            r_tile_base      <= '0;
            r_count          <= '0;
        end else begin
            if (i_cfg_we) begin
                r_vram_base <= i_cfg_wdata;
            end
            if (accept && kind == tbe_pkg::KIND_HEADER) begin
                r_top_palette    <= (32'(top_idx) < tbe_pkg::PAL_ENTRIES)
                    ? r_pal_mem[top_idx[tbe_pkg::PAL_IDX_W-1:0]] : 16'h0000;
                r_bottom_palette <= (32'(bot_idx) < tbe_pkg::PAL_ENTRIES)
                    ? r_pal_mem[bot_idx[tbe_pkg::PAL_IDX_W-1:0]] : 16'h0000;
                r_tile_base      <= n_tile_base;
                r_count          <= '0;
            end else if (accept && kind == tbe_pkg::KIND_PATTERN) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Resolve the pattern byte against the palette of its half of the tile.
    assign row  = r_count[tbe_pkg::COUNT_W-1:2];
    assign col  = r_count[1:0];
    assign word = (32'(row) < tbe_pkg::TILE_ROWS / 2) ? r_top_palette : r_bottom_palette;

    always_comb begin
        o_push       = accept && kind == tbe_pkg::KIND_PATTERN;
        o_work.addr  = r_tile_base
            + tbe_pkg::ADDR_W'(row) * tbe_pkg::ADDR_W'(tbe_pkg::ROW_STRIDE)
            + tbe_pkg::ADDR_W'({col, 1'b0});
        o_work.left  = {tbe_pkg::color_of(word, i_pattern_byte[7:6]),
                        tbe_pkg::color_of(word, i_pattern_byte[5:4])};
        o_work.right = {tbe_pkg::color_of(word, i_pattern_byte[3:2]),
                        tbe_pkg::color_of(word, i_pattern_byte[1:0])};
        o_work.last  = (r_count == {tbe_pkg::COUNT_W{1'b1}});
    end

endmodule

### hw/rtl/tbe_queue.sv
// ----------------------------------------------------------------------------
// tbe_queue: work queue between front end and output sequencer
// A short FIFO of work records so each side can stall on its own.
// ----------------------------------------------------------------------------
module tbe_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tbe_pkg::t_work i_work,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output tbe_pkg::t_work o_work
);

    tbe_pkg::t_work              r_slot [tbe_pkg::QUEUE_DEPTH];
    logic [tbe_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [tbe_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [tbe_pkg::QCNT_W-1:0]  r_count;

    logic                        do_push;
    logic                        do_pop;

    assign o_full  = (32'(r_count) == tbe_pkg::QUEUE_DEPTH);
    assign o_valid = (r_count != '0);
    assign o_work  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_work;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == tbe_pkg::QUEUE_DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == tbe_pkg::QUEUE_DEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/tbe_back.sv
// ----------------------------------------------------------------------------
// tbe_back: output sequencer
// Holds one work record in the output register and delivers it as two
// transactions: the left pixel pair, then the right pair at the next address.
// ----------------------------------------------------------------------------
module tbe_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  tbe_pkg::t_work             i_work,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [tbe_pkg::ADDR_W-1:0] o_vram_address,
    output logic [7:0]                 o_pixel_pair,
    output logic                       o_tile_last
);

    tbe_pkg::t_work r_work;
    logic           r_valid;
    logic           r_second;

    logic           out_accept;
    logic           free;

    assign out_accept = r_valid && i_out_ready;
    // The register frees up once the second half has been taken.
    assign free       = !r_valid || (r_second && i_out_ready);
    assign o_pop      = free && i_q_valid;

    // Output register and half select.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (o_pop) begin
            r_valid  <= 1'b1;
            r_second <= 1'b0;
        end else if (out_accept) begin
            if (r_second) begin
                r_valid <= 1'b0;
            end else begin
                r_second <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_work <= i_work;
        end
    end

    // Result fields for the current half.
    assign o_out_valid    = r_valid;
    assign o_vram_address = r_second ? r_work.addr + 1'b1 : r_work.addr;
    assign o_pixel_pair   = r_second ? r_work.right : r_work.left;
    assign o_tile_last    = r_second && r_work.last;

endmodule

### hw/rtl/tile_2bpp_to_4bpp_expander.sv
// ----------------------------------------------------------------------------
// tile_2bpp_to_4bpp_expander: 2bpp tile to 4bpp video memory write expander
// Top level: front end, work queue and output sequencer.
// ----------------------------------------------------------------------------
// Palette writes and tile headers are absorbed by the front end and
// produce no transactions; a tile header may be followed by a pattern
// byte in the very next cycle. Each pattern byte produces two output
// transactions, and the output port moves one transaction per cycle
// while i_out_ready is high. Input is accepted whenever the two-entry
// work queue has room, so a stalled output side holds off input only
// after the queue and the output register have filled. The vram_base
// register must be written while the block is idle; it takes effect at
// the next tile header.
module tile_2bpp_to_4bpp_expander (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_kind,
    input  logic [3:0]                 i_palette_index,
    input  logic [15:0]                i_palette_word,
    input  logic [7:0]                 i_tile_id,
    input  logic [7:0]                 i_color_byte,
    input  logic [7:0]                 i_pattern_byte,
    input  logic                       i_cfg_we,
    input  logic [tbe_pkg::ADDR_W-1:0] i_cfg_wdata,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [tbe_pkg::ADDR_W-1:0] o_vram_address,
    output logic [7:0]                 o_pixel_pair,
    output logic                       o_tile_last
);

    logic           q_full;
    logic           push;
    tbe_pkg::t_work push_work;
    logic           q_valid;
    logic           pop;
    tbe_pkg::t_work q_work;

    // Front end: classify items and resolve pattern bytes.
    tbe_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_palette_index (i_palette_index),
        .i_palette_word  (i_palette_word),
        .i_tile_id       (i_tile_id),
        .i_color_byte    (i_color_byte),
        .i_pattern_byte  (i_pattern_byte),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_work          (push_work)
    );

    // Work queue between the two sides.
    tbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (push_work),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_work  (q_work)
    );

    // Output sequencer: two transactions per work record.
    tbe_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_work         (q_work),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_vram_address (o_vram_address),
        .o_pixel_pair   (o_pixel_pair),
        .o_tile_last    (o_tile_last)
    );

endmodule
